>>> rtl/text_console_char_writer_core_assert.svh
// Assertion helpers for the RTL files that check their own logic (tcw_back includes them).
`ifndef TEXT_CONSOLE_CHAR_WRITER_CORE_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_WRITER_CORE_ASSERT_SVH

// The property must hold at every clock edge outside reset.
`define TCW_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// When the condition holds, the property holds in the same cycle.
`define TCW_ASSERT_IMPLY(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// When the condition holds, the property holds in the following cycle.
`define TCW_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

>>> rtl/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

    localparam int ROW_FW  = 5;
    localparam int COL_FW  = 7;
    localparam int GUARD_W = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [1:0] MODE_PUT   = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] BLANK_CHAR   = 8'h20;
    localparam logic [7:0] RESET_ATTR   = 8'h07;
    localparam logic [GUARD_W-1:0] RESET_GUARD = 7'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ATTR    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROMPT_GUARD = 1'd1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [1:0]        mode;
        logic [7:0]        char_code;
        logic [ROW_FW-1:0] read_row;
        logic [COL_FW-1:0] read_col;
    } t_in_item;

    typedef struct packed {
        logic [ROW_FW-1:0] cursor_row;
        logic [COL_FW-1:0] cursor_col;
        logic [7:0]        cell_char;
        logic [7:0]        cell_attr;
        logic              scrolled;
    } t_out_item;

    typedef struct packed {
        logic [7:0]         text_attribute;
        logic [GUARD_W-1:0] prompt_guard;
    } t_cfg;

    typedef struct packed {
        logic [7:0] attr;
        logic [7:0] ch;
    } t_cell;

    typedef enum logic [2:0] {
        CMD_PUT,
        CMD_NEWLINE,
        CMD_BACKSPACE,
        CMD_CLEAR,
        CMD_READ,
        CMD_NOP
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind         kind;
        logic [7:0]        char_code;
        logic [ROW_FW-1:0] read_row;
        logic [COL_FW-1:0] read_col;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_FILL,
        ST_SCROLL,
        ST_BLANK,
        ST_READ_WAIT
    } t_back_state;

endpackage

`default_nettype wire

>>> rtl/tcw_ram.sv
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/tcw_front.sv
`default_nettype none

module tcw_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept_en,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tcw_pkg::t_in_item i_in_item,
    output logic              o_cmd_valid,
    output tcw_pkg::t_cmd     o_cmd,
    input  logic              i_cmd_pop
);

    import tcw_pkg::*;

    t_cmd              w_cmd;
    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QPTR_W:0]   n_count;
    logic              w_push;

    // Newline and backspace are told apart here so the executor only branches on kind.
    always_comb begin
        w_cmd.char_code = i_in_item.char_code;
        w_cmd.read_row  = i_in_item.read_row;
        w_cmd.read_col  = i_in_item.read_col;
        case (i_in_item.mode)
            MODE_PUT: begin
                if (i_in_item.char_code == CH_NEWLINE) begin
                    w_cmd.kind = CMD_NEWLINE;
                end else if (i_in_item.char_code == CH_BACKSPACE) begin
                    w_cmd.kind = CMD_BACKSPACE;
                end else begin
                    w_cmd.kind = CMD_PUT;
                end
            end
            MODE_CLEAR: w_cmd.kind = CMD_CLEAR;
            MODE_READ:  w_cmd.kind = CMD_READ;
            default:    w_cmd.kind = CMD_NOP;
        endcase
    end

    assign o_in_ready  = i_accept_en && (r_count != (QPTR_W+1)'(QUEUE_DEPTH));
    assign w_push      = i_in_valid && o_in_ready;
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_cmd_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({w_push, i_cmd_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

`default_nettype wire

>>> rtl/tcw_back.sv
`default_nettype none

`include "text_console_char_writer_core_assert.svh"

module tcw_back #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  tcw_pkg::t_cmd      i_cmd,
    output logic               o_cmd_pop,
    input  tcw_pkg::t_cfg      i_cfg,
    output logic               o_accept_en,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tcw_pkg::t_out_item o_out_item
);

    import tcw_pkg::*;

    localparam int NCELLS = ROWS * COLS;
    localparam int AW     = $clog2(NCELLS);
    localparam int RW     = $clog2(ROWS);
    localparam int CW     = $clog2(COLS);
    localparam int COPY_N = (ROWS - 1) * COLS;
    localparam int CMPW   = (CW > GUARD_W) ? CW : GUARD_W;
    localparam logic [CW:0]   COLS_END = (CW+1)'(COLS);
    localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
    localparam logic [AW-1:0] ADDR_LAST = AW'(NCELLS - 1);
    localparam logic [AW-1:0] ADDR_COPY = AW'(COPY_N);

    t_back_state   r_state;
    t_back_state   n_state;
    logic [RW-1:0] r_row;
    logic [RW-1:0] n_row;
    logic [CW-1:0] r_col;
    logic [CW-1:0] n_col;
    logic [AW-1:0] r_addr;
    logic [AW-1:0] n_addr;
    logic          r_out_valid;
    logic          n_out_valid;
    t_out_item     r_out;
    t_out_item     n_out;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    t_cell         w_wdata;
    logic [AW-1:0] w_raddr;
    t_cell         w_rdata;

    logic          w_slot_free;
    logic          w_pop;
    logic [AW-1:0] w_cur_addr;
    logic [AW-1:0] w_rd_addr;
    logic          w_rd_in_range;
    logic [CW:0]   w_col_inc;
    logic          w_col_wrap;
    logic          w_row_last;
    logic          w_bs_act;
    logic          w_scroll;
    logic          w_fin;
    logic          w_fin_scroll;
    t_cell         w_fin_cell;

    tcw_ram #(
        .WIDTH ($bits(t_cell)),
        .DEPTH (NCELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_pop       = (r_state == ST_IDLE) && i_cmd_valid && w_slot_free;
    assign o_cmd_pop   = w_pop;
    assign o_accept_en = (r_state != ST_INIT);

    assign w_cur_addr    = AW'(32'(r_row) * COLS + 32'(r_col));
    assign w_rd_addr     = AW'(32'(i_cmd.read_row) * COLS + 32'(i_cmd.read_col));
    assign w_rd_in_range = (32'(i_cmd.read_row) < ROWS) && (32'(i_cmd.read_col) < COLS);
    assign w_col_inc     = {1'b0, r_col} + 1'b1;
    assign w_col_wrap    = (w_col_inc == COLS_END);
    assign w_row_last    = (r_row == ROW_LAST);
    assign w_bs_act      = CMPW'(r_col) > CMPW'(i_cfg.prompt_guard);
    assign w_scroll      = ((i_cmd.kind == CMD_PUT) && w_col_wrap && w_row_last)
                        || ((i_cmd.kind == CMD_NEWLINE) && w_row_last);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (r_addr == ADDR_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_pop) begin
                    case (i_cmd.kind)
                        CMD_CLEAR: n_state = ST_FILL;
                        CMD_READ:  n_state = w_rd_in_range ? ST_READ_WAIT : ST_IDLE;
                        CMD_PUT, CMD_NEWLINE: begin
                            n_state = w_scroll ? ST_SCROLL : ST_IDLE;
                        end
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_FILL: begin
                if (r_addr == ADDR_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCROLL: begin
                if (r_addr == ADDR_COPY) begin
                    n_state = ST_BLANK;
                end
            end
            ST_BLANK: begin
                if (r_addr == ADDR_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_READ_WAIT: n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_row        = r_row;
        n_col        = r_col;
        n_addr       = r_addr;
        w_we         = 1'b0;
        w_waddr      = r_addr;
        w_wdata      = '{attr: i_cfg.text_attribute, ch: BLANK_CHAR};
        w_raddr      = AW'(32'(r_addr) + COLS);
        w_fin        = 1'b0;
        w_fin_scroll = 1'b0;
        w_fin_cell   = '0;
        case (r_state)
            ST_INIT: begin
                w_we    = 1'b1;
                w_wdata = '{attr: RESET_ATTR, ch: BLANK_CHAR};
                n_addr  = (r_addr == ADDR_LAST) ? '0 : r_addr + 1'b1;
            end
            ST_IDLE: begin
                if (w_pop) begin
                    n_addr = '0;
                    case (i_cmd.kind)
                        CMD_PUT: begin
                            w_we    = 1'b1;
                            w_waddr = w_cur_addr;
                            w_wdata = '{attr: i_cfg.text_attribute, ch: i_cmd.char_code};
                            if (w_col_wrap) begin
                                n_col = '0;
                                if (!w_row_last) begin
                                    n_row = r_row + 1'b1;
                                end
                            end else begin
                                n_col = CW'(w_col_inc);
                            end
                            w_fin = !w_scroll;
                        end
                        CMD_NEWLINE: begin
                            n_col = '0;
                            if (!w_row_last) begin
                                n_row = r_row + 1'b1;
                            end
                            w_fin = !w_row_last;
                        end
                        CMD_BACKSPACE: begin
                            if (w_bs_act) begin
                                w_we    = 1'b1;
                                w_waddr = w_cur_addr - 1'b1;
                                n_col   = r_col - 1'b1;
                            end
                            w_fin = 1'b1;
                        end
                        CMD_CLEAR: begin
                            n_row = '0;
                            n_col = '0;
                        end
                        CMD_READ: begin
                            w_raddr = w_rd_addr;
                            w_fin   = !w_rd_in_range;
                        end
                        default: w_fin = 1'b1;
                    endcase
                end
            end
            ST_FILL: begin
                w_we = 1'b1;
                if (r_addr == ADDR_LAST) begin
                    n_addr = '0;
                    w_fin  = 1'b1;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            ST_SCROLL: begin
                // Each cycle reads the cell one row below and writes what the previous cycle read.
                if (r_addr != '0) begin
                    w_we    = 1'b1;
                    w_waddr = r_addr - 1'b1;
                    w_wdata = w_rdata;
                end
                if (r_addr != ADDR_COPY) begin
                    n_addr = r_addr + 1'b1;
                end
            end
            ST_BLANK: begin
                w_we = 1'b1;
                if (r_addr == ADDR_LAST) begin
                    n_addr       = '0;
                    w_fin        = 1'b1;
                    w_fin_scroll = 1'b1;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            ST_READ_WAIT: begin
                w_fin      = 1'b1;
                w_fin_cell = w_rdata;
            end
            default: begin
            end
        endcase

        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        if (w_fin) begin
            n_out_valid      = 1'b1;
            n_out.cursor_row = ROW_FW'(n_row);
            n_out.cursor_col = COL_FW'(n_col);
            n_out.cell_char  = w_fin_cell.ch;
            n_out.cell_attr  = w_fin_cell.attr;
            n_out.scrolled   = w_fin_scroll;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_row       <= '0;
            r_col       <= '0;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_addr      <= n_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `TCW_ASSERT_ALWAYS(a_cursor_on_screen, i_clk, i_rst_n,
        (32'(r_row) < ROWS) && (32'(r_col) < COLS),
        "cursor left the screen")
    `TCW_ASSERT_IMPLY(a_scroll_cursor, i_clk, i_rst_n,
        r_out_valid && r_out.scrolled,
        (r_out.cursor_col == '0) && (r_out.cursor_row == ROW_FW'(ROWS - 1)),
        "scroll result with cursor off the last row start")
    `TCW_ASSERT_IMPLY(a_write_in_store, i_clk, i_rst_n,
        w_we, 32'(w_waddr) < NCELLS,
        "screen write beyond the last cell")
    `TCW_ASSERT_NEXT(a_read_delivers, i_clk, i_rst_n,
        r_state == ST_READ_WAIT, r_out_valid,
        "cell read gave no result")

endmodule

`default_nettype wire

>>> rtl/text_console_char_writer_core.sv
// Channel  Handshake                   Payload                   Beat
// in       i_in_valid / o_in_ready     i_in_item                 one command
// out      o_out_valid / i_out_ready   o_out_item                one result per command
// cfg      i_cfg_we                    i_cfg_index, i_cfg_data   one register write
//
// Put, newline, backspace, unused modes and out-of-range reads finish in the command cycle;
// an in-range read adds a registered screen read (ST_READ_WAIT). A clear then writes one cell
// per cycle over the single write port. A scrolling put or newline then copies the rows up
// (ST_SCROLL) and blanks the bottom row (ST_BLANK).
// After reset a clearing pass fills the screen with o_in_ready low.
// A two-entry command queue keeps taking beats while a result waits on out.
`default_nettype none

module text_console_char_writer_core #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  tcw_pkg::t_in_item                  i_in_item,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output tcw_pkg::t_out_item                 o_out_item,
    input  logic                               i_cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    import tcw_pkg::*;

    t_cfg r_cfg;
    t_cmd w_cmd;
    logic w_cmd_valid;
    logic w_cmd_pop;
    logic w_accept_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.text_attribute <= RESET_ATTR;
            r_cfg.prompt_guard   <= RESET_GUARD;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TEXT_ATTR:    r_cfg.text_attribute <= i_cfg_data;
                CFG_PROMPT_GUARD: r_cfg.prompt_guard   <= i_cfg_data[GUARD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    tcw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept_en (w_accept_en),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    tcw_back #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .i_cfg       (r_cfg),
        .o_accept_en (w_accept_en),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

>>> dv/text_console_char_writer_core_tb.sv
`timescale 1ns / 1ps

module text_console_char_writer_core_tb;
    import tcw_pkg::*;

    localparam int COLS = 80;
    localparam int ROWS = 25;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  cfg_idx;
        logic [CFG_DATA_W-1:0] cfg_val;
        t_in_item              cmd;
        bit                    typed;
        t_out_item             want;
    } t_plan_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_item = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_item;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Shadow copy of the console state.
    t_cell              screen [ROWS*COLS];
    int                 cur_row;
    int                 cur_col;
    logic [7:0]         text_attr;
    logic [GUARD_W-1:0] guard;

    t_out_item console_results_q[$];
    int        mismatches = 0;
    bit        no_gaps = 1'b0;
    int        ready_left = 0;
    t_plan_row plan [22];

    text_console_char_writer_core #(
        .COLS(COLS),
        .ROWS(ROWS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_in_item mk_cmd(logic [1:0] mode, logic [7:0] ch, int rr, int rc);
        t_in_item c;
        c.mode      = mode;
        c.char_code = ch;
        c.read_row  = rr[ROW_FW-1:0];
        c.read_col  = rc[COL_FW-1:0];
        return c;
    endfunction

    function automatic t_out_item mk_res(int row, int col, logic [7:0] ch, logic [7:0] attr,
                                         int scr);
        t_out_item r;
        r.cursor_row = row[ROW_FW-1:0];
        r.cursor_col = col[COL_FW-1:0];
        r.cell_char  = ch;
        r.cell_attr  = attr;
        r.scrolled   = scr[0];
        return r;
    endfunction

    function automatic t_plan_row row_cmd(t_in_item c);
        return '{1'b0, '0, '0, c, 1'b0, '0};
    endfunction

    function automatic t_plan_row row_chk(t_in_item c, t_out_item w);
        return '{1'b0, '0, '0, c, 1'b1, w};
    endfunction

    function automatic t_plan_row row_cfg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
        return '{1'b1, idx, val, '0, 1'b0, '0};
    endfunction

    // Applies one command to the shadow console and returns its result.
    function automatic t_out_item console_step(t_in_item c);
        t_out_item r;
        int i;
        r = '0;
        case (c.mode)
            MODE_PUT: begin
                if (c.char_code == CH_NEWLINE) begin
                    cur_col = 0;
                    cur_row++;
                end else if (c.char_code == CH_BACKSPACE) begin
                    if (cur_col > int'(guard)) begin
                        cur_col--;
                        screen[cur_row*COLS + cur_col] = t_cell'{attr: text_attr, ch: BLANK_CHAR};
                    end
                end else begin
                    screen[cur_row*COLS + cur_col] = t_cell'{attr: text_attr, ch: c.char_code};
                    cur_col++;
                end
                if (cur_col >= COLS) begin
                    cur_col = 0;
                    cur_row++;
                end
                if (cur_row >= ROWS) begin
                    for (i = 0; i < (ROWS-1)*COLS; i++)
                        screen[i] = screen[i + COLS];
                    for (i = (ROWS-1)*COLS; i < ROWS*COLS; i++)
                        screen[i] = t_cell'{attr: text_attr, ch: BLANK_CHAR};
                    cur_row    = ROWS - 1;
                    r.scrolled = 1'b1;
                end
            end
            MODE_CLEAR: begin
                for (i = 0; i < ROWS*COLS; i++)
                    screen[i] = t_cell'{attr: text_attr, ch: BLANK_CHAR};
                cur_row = 0;
                cur_col = 0;
            end
            MODE_READ: begin
                if (int'(c.read_row) < ROWS && int'(c.read_col) < COLS) begin
                    r.cell_char = screen[c.read_row*COLS + c.read_col].ch;
                    r.cell_attr = screen[c.read_row*COLS + c.read_col].attr;
                end
            end
            default: ;
        endcase
        r.cursor_row = cur_row[ROW_FW-1:0];
        r.cursor_col = cur_col[COL_FW-1:0];
        return r;
    endfunction

    // Mostly back to back, sometimes a short gap, rarely a long pause.
    function automatic int next_gap();
        int p;
        p = $urandom_range(0, 99);
        if (no_gaps || p < 65)
            return 0;
        else if (p < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Text typing with newlines and backspaces, plus reads, clears and noise.
    // Newlines are rare on the last row so that scrolls stay affordable.
    function automatic t_in_item next_command();
        t_in_item c;
        int p;
        int nl_pct;
        c = mk_cmd(MODE_PUT, 8'($urandom_range(0, 255)), $urandom_range(0, 31),
                   $urandom_range(0, 127));
        nl_pct = (cur_row == ROWS-1) ? 2 : 9;
        p = $urandom_range(0, 99);
        if (p < 2) begin
            c.mode = MODE_UNUSED;
        end else if (p < 4) begin
            c.mode = MODE_CLEAR;
        end else if (p < 24) begin
            c.mode = MODE_READ;
            p = $urandom_range(0, 9);
            if (p < 5) begin
                c.read_row = cur_row[ROW_FW-1:0];
                c.read_col = COL_FW'($urandom_range(0, cur_col));
            end else if (p < 9) begin
                c.read_row = ROW_FW'($urandom_range(0, ROWS-1));
                c.read_col = COL_FW'($urandom_range(0, COLS-1));
            end
        end else begin
            p = $urandom_range(0, 99);
            if (p < nl_pct)
                c.char_code = CH_NEWLINE;
            else if (p < 22)
                c.char_code = CH_BACKSPACE;
        end
        return c;
    endfunction

    task automatic send(t_in_item c, bit typed, t_out_item want);
        int gap;
        t_out_item r;
        gap = next_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= c;
        do @(posedge i_clk); while (!o_in_ready);
        r = console_step(c);
        console_results_q.push_back(typed ? want : r);
    endtask

    // Stops sending and waits until every outstanding result has come back.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (console_results_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_TEXT_ATTR)
            text_attr = val;
        else
            guard = val[GUARD_W-1:0];
    endtask

    // Result side: long stretches of ready with random stalls in between.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            ready_left  <= 0;
        end else if (ready_left != 0) begin
            ready_left <= ready_left - 1;
        end else if (i_out_ready && $urandom_range(0, 3) == 0) begin
            ready_left <= $urandom_range(0, 40);
        end else begin
            i_out_ready <= ~i_out_ready;
            ready_left  <= i_out_ready ? next_gap() : $urandom_range(0, 12);
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (console_results_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: row %0d col %0d char %h attr %h scr %0b",
                             o_out_item.cursor_row, o_out_item.cursor_col,
                             o_out_item.cell_char, o_out_item.cell_attr, o_out_item.scrolled);
            end else begin
                want = console_results_q.pop_front();
                if (o_out_item.cursor_row !== want.cursor_row ||
                    o_out_item.cursor_col !== want.cursor_col ||
                    o_out_item.cell_char !== want.cell_char ||
                    o_out_item.cell_attr !== want.cell_attr ||
                    o_out_item.scrolled !== want.scrolled) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %0d,%0d %h:%h %0b got %0d,%0d %h:%h %0b",
                                 want.cursor_row, want.cursor_col, want.cell_char,
                                 want.cell_attr, want.scrolled,
                                 o_out_item.cursor_row, o_out_item.cursor_col,
                                 o_out_item.cell_char, o_out_item.cell_attr,
                                 o_out_item.scrolled);
                end
            end
        end
    end

    initial begin
        #(300_000_000);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int i;
        int ph;
        int n;
        logic [7:0] attr_val;
        logic [7:0] guard_val;

        for (i = 0; i < ROWS*COLS; i++)
            screen[i] = t_cell'{attr: RESET_ATTR, ch: BLANK_CHAR};
        cur_row   = 0;
        cur_col   = 0;
        text_attr = RESET_ATTR;
        guard     = RESET_GUARD;

        plan[0]  = row_chk(mk_cmd(MODE_READ, 8'h00, 0, 0), mk_res(0, 0, BLANK_CHAR, RESET_ATTR, 0));
        plan[1]  = row_chk(mk_cmd(MODE_READ, 8'h00, 24, 79),
                           mk_res(0, 0, BLANK_CHAR, RESET_ATTR, 0));
        plan[2]  = row_chk(mk_cmd(MODE_READ, 8'hFF, 31, 127), mk_res(0, 0, 8'h00, 8'h00, 0));
        plan[3]  = row_chk(mk_cmd(MODE_READ, 8'h00, 25, 0), mk_res(0, 0, 8'h00, 8'h00, 0));
        plan[4]  = row_chk(mk_cmd(MODE_READ, 8'h00, 0, 80), mk_res(0, 0, 8'h00, 8'h00, 0));
        plan[5]  = row_chk(mk_cmd(MODE_UNUSED, 8'hFF, 31, 127), mk_res(0, 0, 8'h00, 8'h00, 0));
        // Character zero is stored like any other byte.
        plan[6]  = row_chk(mk_cmd(MODE_PUT, 8'h00, 0, 0), mk_res(0, 1, 8'h00, 8'h00, 0));
        plan[7]  = row_chk(mk_cmd(MODE_READ, 8'h00, 0, 0), mk_res(0, 1, 8'h00, RESET_ATTR, 0));
        // The column is below the prompt guard, so the backspace is ignored.
        plan[8]  = row_chk(mk_cmd(MODE_PUT, CH_BACKSPACE, 0, 0), mk_res(0, 1, 8'h00, 8'h00, 0));
        plan[9]  = row_cfg(CFG_PROMPT_GUARD, 8'd0);
        plan[10] = row_cfg(CFG_TEXT_ATTR, 8'hFF);
        plan[11] = row_chk(mk_cmd(MODE_PUT, CH_BACKSPACE, 0, 0), mk_res(0, 0, 8'h00, 8'h00, 0));
        plan[12] = row_chk(mk_cmd(MODE_READ, 8'h00, 0, 0), mk_res(0, 0, BLANK_CHAR, 8'hFF, 0));
        plan[13] = row_cmd(mk_cmd(MODE_PUT, 8'hFF, 31, 127));
        plan[14] = row_cmd(mk_cmd(MODE_PUT, CH_NEWLINE, 0, 0));
        plan[15] = row_cmd(mk_cmd(MODE_PUT, 8'h41, 0, 0));
        plan[16] = row_cmd(mk_cmd(MODE_PUT, CH_BACKSPACE, 0, 0));
        plan[17] = row_cfg(CFG_TEXT_ATTR, 8'h00);
        plan[18] = row_chk(mk_cmd(MODE_CLEAR, 8'hFF, 31, 127), mk_res(0, 0, 8'h00, 8'h00, 0));
        plan[19] = row_chk(mk_cmd(MODE_READ, 8'h00, 12, 40), mk_res(0, 0, BLANK_CHAR, 8'h00, 0));
        plan[20] = row_chk(mk_cmd(MODE_PUT, CH_BACKSPACE, 0, 0), mk_res(0, 0, 8'h00, 8'h00, 0));
        plan[21] = row_cfg(CFG_PROMPT_GUARD, 8'd79);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < 22; i++) begin
            if (plan[i].is_cfg) begin
                settle();
                cfg_write(plan[i].cfg_idx, plan[i].cfg_val);
            end else begin
                send(plan[i].cmd, plan[i].typed, plan[i].want);
            end
        end

        for (ph = 0; ph < 10; ph++) begin
            settle();
            case (ph % 4)
                0: attr_val = 8'h00;
                1: attr_val = 8'hFF;
                default: attr_val = 8'($urandom_range(0, 255));
            endcase
            case (ph % 3)
                0: guard_val = 8'd0;
                1: guard_val = 8'd79;
                default: guard_val = 8'($urandom_range(0, 20));
            endcase
            cfg_write(CFG_TEXT_ATTR, attr_val);
            cfg_write(CFG_PROMPT_GUARD, guard_val);
            no_gaps = ($urandom_range(0, 3) == 0);
            for (n = 0; n < 110; n++)
                send(next_command(), 1'b0, '0);
        end

        settle();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && console_results_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
